>>> sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CHK_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CHK_HOLDS(lbl, clk, rst, prop, msg)
`define CHK_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/hce_pkg.sv
package hce_pkg;

  localparam int unsigned Q = 31;
  localparam logic [63:0] LN2_Q31 = 64'd1488522236;
  localparam logic [63:0] RECIP_LN2 = (64'd1 << 51) / LN2_Q31;
  localparam int unsigned SERIES_TERMS = 15;

  typedef struct packed {
    logic [15:0] xm;
    logic [15:0] ym;
    logic        xneg;
    logic        yneg;
    logic        outside;
    logic [31:0] n2;
    logic [4:0]  nexp;
  } geo_t;

  typedef struct packed {
    geo_t        geo;
    logic [30:0] s;
  } sq_side_t;

  typedef struct packed {
    geo_t        geo;
    logic [31:0] c;
  } ab_side_t;

  typedef struct packed {
    geo_t        geo;
    logic [32:0] rmag;
    logic        mneg;
  } xy_side_t;

endpackage

>>> sv/hce_div.sv
module hce_div #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic [QW:0]    v;
  logic [DW-1:0]  rem  [0:QW];
  logic [QW-1:0]  low  [0:QW];
  logic [QW-1:0]  q    [0:QW];
  logic [DW-1:0]  d    [0:QW];
  logic [SW-1:0]  sd   [0:QW];
  logic [NW+DW-1:0] wide;

  assign wide = {{DW{1'b0}}, num};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= wide[QW +: DW];
      low[0] <= num[QW-1:0];
      q[0]   <= '0;
      d[0]   <= den;
      sd[0]  <= in_side;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rem[j], low[j][QW-1]};
    assign diff  = trial - {1'b0, d[j]};
    assign ge    = trial >= {1'b0, d[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low[j+1] <= low[j] << 1;
        q[j+1]   <= {q[j][QW-2:0], ge};
        d[j+1]   <= d[j];
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign out_valid = v[QW];
  assign quo       = q[QW];
  assign out_side  = sd[QW];

endmodule

>>> sv/hce_sqrt.sv
module hce_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   root,
  output logic [SW-1:0] out_side
);

  localparam int STEPS = 32;

  logic [STEPS:0] v;
  logic [63:0]    rem [0:STEPS];
  logic [63:0]    rt  [0:STEPS];
  logic [SW-1:0]  sd  [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= rad;
      rt[0]  <= '0;
      sd[0]  <= in_side;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    assign trial = rt[i] + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[i] >= trial) begin
          rem[i+1] <= rem[i] - trial;
          rt[i+1]  <= (rt[i] >> 1) + BITV;
        end else begin
          rem[i+1] <= rem[i];
          rt[i+1]  <= rt[i] >> 1;
        end
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = v[STEPS];
  assign root      = rt[STEPS][31:0];
  assign out_side  = sd[STEPS];

endmodule

>>> sv/hce_exp.sv
module hce_exp #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [30:0]   f,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [32:0]   ef,
  output logic [SW-1:0] out_side
);

  localparam int NT = hce_pkg::SERIES_TERMS;

  logic          cv [0:NT];
  logic [31:0]   ct [0:NT];
  logic [32:0]   ce [0:NT];
  logic [30:0]   cf [0:NT];
  logic [SW-1:0] cs [0:NT];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ct[0] <= 32'h8000_0000;
      ce[0] <= 33'h0_8000_0000;
      cf[0] <= f;
      cs[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= NT; k++) begin : g_term
    localparam logic [32:0] RK = 33'((64'd1 << 32) / k);
    localparam logic [35:0] KK = 36'(k);
    logic          va, vb;
    logic [62:0]   pa;
    logic [31:0]   xb, qb;
    logic [30:0]   fa, fb;
    logic [32:0]   ea, eb;
    logic [SW-1:0] sa, sb;
    logic [64:0]   pr;
    logic [35:0]   r;
    logic [31:0]   term;

    assign pr   = {1'b0, pa[62:31]} * {32'd0, RK};
    assign r    = {4'd0, xb} - {4'd0, qb} * KK;
    assign term = qb + {31'd0, (r >= KK)};

    always_ff @(posedge clk) begin
      if (rst) begin
        va    <= 1'b0;
        vb    <= 1'b0;
        cv[k] <= 1'b0;
      end else if (en) begin
        va    <= cv[k-1];
        vb    <= va;
        cv[k] <= vb;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pa    <= {31'd0, ct[k-1]} * {32'd0, cf[k-1]};
        fa    <= cf[k-1];
        ea    <= ce[k-1];
        sa    <= cs[k-1];
        xb    <= pa[62:31];
        qb    <= pr[63:32];
        fb    <= fa;
        eb    <= ea;
        sb    <= sa;
        ct[k] <= term;
        ce[k] <= eb + {1'b0, term};
        cf[k] <= fb;
        cs[k] <= sb;
      end
    end
  end

  assign out_valid = cv[NT];
  assign ef        = ce[NT];
  assign out_side  = cs[NT];

endmodule

>>> sv/hyperbolic_circle_to_euclidean_core.sv
// Poincare disk circle converter: takes a hyperbolic circle (center, radius)
// and returns the Euclidean center and radius of the same circle.
// Input channel s_*: one word per circle, center_x and center_y in signed
// Q1.15 (scaled by FRAC_BITS) and hyp_radius in unsigned Q4.12.
// Output channel m_*: one word per input word, in the same order; m_tuser
// carries outside_disk, which zeroes the other fields when |center| >= 1.
// Throughput: one word per cycle while m_tready stays high, with no gaps between back-to-back words.
// The pipeline depth is set by the series stages of exp(-r), the
// one-bit-per-stage dividers (four in series) and the square-root stages.
// The whole pipeline advances together; when m_tready is low with a word
// waiting on m_*, every stage holds and s_tready drops, so no word is lost
// or repeated. Bubbles travel through the pipeline as cleared valid bits.
// Reset (rst, synchronous) clears every valid bit; words in flight are
// dropped and the pipeline comes up empty and ready.
`include "assert_macros.svh"

module hyperbolic_circle_to_euclidean_core #(
  parameter int FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // center_x[15:0], center_y[31:16], hyp_radius[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // euclid_x[15:0], euclid_y[31:16], euclid_radius[47:32]
  output logic [0:0]  m_tuser   // outside_disk[0]
);

  localparam int SH = 31 - FRAC_BITS;
  localparam logic [33:0] RLIM = (FRAC_BITS >= 16) ? 34'd65535 : (34'd1 << FRAC_BITS);
  localparam logic [63:0] N2_LIM = 64'd1 << (2 * FRAC_BITS);
  localparam int SQ_SHIFT = 62 - 2 * FRAC_BITS;
  localparam int GW  = $bits(hce_pkg::geo_t);
  localparam int SQW = $bits(hce_pkg::sq_side_t);
  localparam int ABW = $bits(hce_pkg::ab_side_t);
  localparam int XYW = $bits(hce_pkg::xy_side_t);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input register
  logic               v0;
  logic signed [15:0] x0, y0;
  logic [15:0]        hr0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= s_tdata[15:0];
      y0  <= s_tdata[31:16];
      hr0 <= s_tdata[47:32];
    end
  end

  // magnitudes, squares, range reduction estimate
  logic        v1, xneg1, yneg1;
  logic [15:0] xm1, ym1, hr1;
  logic [31:0] sqx1, sqy1;
  logic [4:0]  n01;
  logic [15:0] xm0, ym0;
  logic [36:0] nprod0;

  assign xm0    = x0[15] ? 16'd0 - x0 : x0;
  assign ym0    = y0[15] ? 16'd0 - y0 : y0;
  assign nprod0 = {21'd0, hr0} * {16'd0, hce_pkg::RECIP_LN2[20:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xm1   <= xm0;
      ym1   <= ym0;
      xneg1 <= x0[15];
      yneg1 <= y0[15];
      sqx1  <= {16'd0, xm0} * {16'd0, xm0};
      sqy1  <= {16'd0, ym0} * {16'd0, ym0};
      n01   <= nprod0[36:32];
      hr1   <= hr0;
    end
  end

  // norm, outside test, remainder of r / ln2
  logic         v2;
  hce_pkg::geo_t geo2;
  logic [35:0]  fraw2;
  logic [31:0]  n2_1;
  logic [35:0]  r31_1, nl_1;

  assign n2_1  = sqx1 + sqy1;
  assign r31_1 = {1'b0, hr1, 19'd0};
  assign nl_1  = {31'd0, n01} * hce_pkg::LN2_Q31[35:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo2.xm      <= xm1;
      geo2.ym      <= ym1;
      geo2.xneg    <= xneg1;
      geo2.yneg    <= yneg1;
      geo2.outside <= {32'd0, n2_1} >= N2_LIM;
      geo2.n2      <= n2_1;
      geo2.nexp    <= n01;
      fraw2        <= r31_1 - nl_1;
    end
  end

  // correct the range reduction
  logic          v3;
  hce_pkg::geo_t geo3, geo3_next;
  logic [30:0]   f3;
  logic          fix2;
  logic [35:0]   fsub2;

  assign fix2  = fraw2 >= hce_pkg::LN2_Q31[35:0];
  assign fsub2 = fraw2 - hce_pkg::LN2_Q31[35:0];

  always_comb begin
    geo3_next      = geo2;
    geo3_next.nexp = fix2 ? geo2.nexp + 5'd1 : geo2.nexp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo3 <= geo3_next;
      f3   <= fix2 ? fsub2[30:0] : fraw2[30:0];
    end
  end

  // exp(f)
  logic          exp_v;
  logic [32:0]   exp_ef;
  logic [GW-1:0] exp_side;

  hce_exp #(.SW(GW)) u_exp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .f        (f3),
    .in_side  (geo3),
    .out_valid(exp_v),
    .ef       (exp_ef),
    .out_side (exp_side)
  );

  // 2^62 / exp(f)
  logic          inv_v;
  logic [31:0]   inv_q;
  logic [GW-1:0] inv_side;

  hce_div #(.NW(63), .DW(33), .QW(32), .SW(GW)) u_div_inv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (exp_v),
    .num      (63'd1 << 62),
    .den      (exp_ef),
    .in_side  (exp_side),
    .out_valid(inv_v),
    .quo      (inv_q),
    .out_side (inv_side)
  );

  // s = (1 - e) / (1 + e)
  hce_pkg::geo_t inv_geo;
  logic [31:0]   e_sh, e_cl;
  logic          th_v;
  logic [30:0]   th_s;
  logic [GW-1:0] th_side;

  assign inv_geo = hce_pkg::geo_t'(inv_side);
  assign e_sh    = inv_q >> inv_geo.nexp;
  assign e_cl    = (e_sh > 32'h8000_0000) ? 32'h8000_0000 : e_sh;

  hce_div #(.NW(63), .DW(33), .QW(31), .SW(GW)) u_div_tanh (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (inv_v),
    .num      ({32'h8000_0000 - e_cl, 31'd0}),
    .den      ({1'b0, 32'h8000_0000} + {1'b0, e_cl}),
    .in_side  (inv_side),
    .out_valid(th_v),
    .quo      (th_s),
    .out_side (th_side)
  );

  // c = |center| in Q31
  hce_pkg::geo_t    th_geo;
  hce_pkg::sq_side_t sq_in;
  logic             sq_v;
  logic [31:0]      sq_c;
  logic [SQW-1:0]   sq_side;
  logic [63:0]      sq_rad;

  assign th_geo     = hce_pkg::geo_t'(th_side);
  assign sq_in.geo  = th_geo;
  assign sq_in.s    = th_s;
  assign sq_rad     = {32'd0, th_geo.n2} << SQ_SHIFT;

  hce_sqrt #(.SW(SQW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (th_v),
    .rad      (sq_rad),
    .in_side  (sq_in),
    .out_valid(sq_v),
    .root     (sq_c),
    .out_side (sq_side)
  );

  // s * c
  hce_pkg::sq_side_t sq_out;
  logic              v5;
  hce_pkg::geo_t     geo5;
  logic [30:0]       s5;
  logic [31:0]       c5, sc5;
  logic [62:0]       scp;

  assign sq_out = hce_pkg::sq_side_t'(sq_side);
  assign scp    = {32'd0, sq_out.s} * {31'd0, sq_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo5 <= sq_out.geo;
      s5   <= sq_out.s;
      c5   <= sq_c;
      sc5  <= scp[62:31];
    end
  end

  // a and b
  logic              aneg5;
  logic [31:0]       absd5;
  logic [32:0]       cs5;
  hce_pkg::ab_side_t ab_in;
  logic              da_v, db_v;
  logic [31:0]       amag, bq;
  logic [ABW-1:0]    da_side;
  logic [0:0]        db_side;

  assign aneg5     = {1'b0, s5} > c5;
  assign absd5     = aneg5 ? {1'b0, s5} - c5 : c5 - {1'b0, s5};
  assign cs5       = {1'b0, c5} + {2'd0, s5};
  assign ab_in.geo = geo5;
  assign ab_in.c   = c5;

  hce_div #(.NW(64), .DW(33), .QW(32), .SW(ABW)) u_div_a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v5),
    .num      ({1'b0, absd5, 31'd0}),
    .den      (33'h0_8000_0000 - {1'b0, sc5}),
    .in_side  (ab_in),
    .out_valid(da_v),
    .quo      (amag),
    .out_side (da_side)
  );

  hce_div #(.NW(64), .DW(33), .QW(32), .SW(1)) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v5),
    .num      ({cs5, 31'd0}),
    .den      (33'h0_8000_0000 + {1'b0, sc5}),
    .in_side  (aneg5),
    .out_valid(db_v),
    .quo      (bq),
    .out_side (db_side)
  );

  // midpoint and half width
  hce_pkg::ab_side_t ab_out;
  logic [34:0]       a35, b35, sum35, dif35, asum, adif;
  logic              v7, mneg7;
  hce_pkg::geo_t     geo7;
  logic [31:0]       c7;
  logic [32:0]       mmag7, rmag7;

  assign ab_out = hce_pkg::ab_side_t'(da_side);
  assign a35    = db_side[0] ? 35'd0 - {3'd0, amag} : {3'd0, amag};
  assign b35    = {3'd0, bq};
  assign sum35  = a35 + b35;
  assign dif35  = b35 - a35;
  assign asum   = sum35[34] ? 35'd0 - sum35 : sum35;
  assign adif   = dif35[34] ? 35'd0 - dif35 : dif35;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= da_v && db_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo7  <= ab_out.geo;
      c7    <= ab_out.c;
      mneg7 <= sum35[34];
      mmag7 <= asum[33:1];
      rmag7 <= adif[33:1];
    end
  end

  // scale the direction
  logic [63:0]       xqw, yqw;
  logic              v8;
  hce_pkg::xy_side_t xy8;
  logic [31:0]       c8;
  logic [64:0]       px8, py8;

  assign xqw = {48'd0, geo7.xm} << SH;
  assign yqw = {48'd0, geo7.ym} << SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xy8.geo  <= geo7;
      xy8.rmag <= rmag7;
      xy8.mneg <= mneg7;
      c8       <= c7;
      px8      <= {32'd0, mmag7} * {33'd0, xqw[31:0]};
      py8      <= {32'd0, mmag7} * {33'd0, yqw[31:0]};
    end
  end

  logic           dx_v, dy_v;
  logic [32:0]    qx, qy;
  logic [XYW-1:0] dx_side;
  logic [0:0]     dy_side;

  hce_div #(.NW(65), .DW(32), .QW(33), .SW(XYW)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v8),
    .num      (px8),
    .den      (c8),
    .in_side  (xy8),
    .out_valid(dx_v),
    .quo      (qx),
    .out_side (dx_side)
  );

  hce_div #(.NW(65), .DW(32), .QW(33), .SW(1)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v8),
    .num      (py8),
    .den      (c8),
    .in_side  (c8 == 32'd0),
    .out_valid(dy_v),
    .quo      (qy),
    .out_side (dy_side)
  );

  // round, clamp, sign, output register
  hce_pkg::xy_side_t xy_out;
  logic [33:0]       rx, ry, rr;
  logic [15:0]       ex, ey, er, fx, fy;

  assign xy_out = hce_pkg::xy_side_t'(dx_side);
  assign rx = ({1'b0, qx} + (34'd1 << (SH - 1))) >> SH;
  assign ry = ({1'b0, qy} + (34'd1 << (SH - 1))) >> SH;
  assign rr = ({1'b0, xy_out.rmag} + (34'd1 << (SH - 1))) >> SH;
  assign ex = dy_side[0] ? 16'd0 : (rx > 34'd32767 ? 16'd32767 : rx[15:0]);
  assign ey = dy_side[0] ? 16'd0 : (ry > 34'd32767 ? 16'd32767 : ry[15:0]);
  assign er = (rr > RLIM) ? RLIM[15:0] : rr[15:0];
  assign fx = (xy_out.mneg != xy_out.geo.xneg) ? 16'd0 - ex : ex;
  assign fy = (xy_out.mneg != xy_out.geo.yneg) ? 16'd0 - ey : ey;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dx_v && dy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (xy_out.geo.outside) begin
        m_tdata <= 48'd0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {er, fy, fx};
        m_tuser <= 1'b0;
      end
    end
  end

  `CHK_IMPLIES(a_out_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0, "outside data")
  `CHK_IMPLIES(a_radius_limit, clk, rst, m_tvalid, {18'd0, m_tdata[47:32]} <= RLIM, "radius limit")
  `CHK_IMPLIES(a_x_range, clk, rst, m_tvalid, m_tdata[15:0] != 16'h8000, "x out of range")
  `CHK_IMPLIES(a_y_range, clk, rst, m_tvalid, m_tdata[31:16] != 16'h8000, "y out of range")
  `CHK_HOLDS(a_stall_blocks, clk, rst, !(m_tvalid && !m_tready) || !s_tready, "taken in stall")

endmodule
